FILE: src/eia_pkg.sv
// eia_pkg: constants, codes and types of the entity id allocator
// no dependencies; used by entity_id_allocator by scoped names
package eia_pkg;

    // id space: ids 1 .. MAX_IDS-1, id 0 is invalid
    localparam int MAX_IDS   = 1024;
    localparam int ID_W      = 10;
    localparam int CNT_W     = 10;
    localparam int FRESH_W   = ID_W + 1;
    localparam int STK_DEPTH = MAX_IDS - 1;

    // live map held as rows of bits
    localparam int ROW_W  = 32;
    localparam int ROWS   = MAX_IDS / ROW_W;
    localparam int BIT_AW = $clog2(ROW_W);
    localparam int ROW_AW = $clog2(ROWS);

    // stream widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // operation codes
    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_SWEEP = 4'b0001,
        S_IDLE  = 4'b0010,
        S_STACK = 4'b0100,
        S_ROW   = 4'b1000
    } t_state;

    // one result, status in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0] live_count;
        logic             is_live;
        logic [ID_W-1:0]  result_id;
        t_status          status;
    } t_result;

endpackage

FILE: src/entity_id_allocator.sv
// entity_id_allocator: id allocator with a lifo free stack and a live bitmap
// depends on eia_pkg; live map and free stack are internal synchronous memories
//
// a create, destroy or query request reads the stack at acceptance, then its live
//   row, then commits and registers its result; no new request is taken until it
//   has committed, and a waiting result that is not yet taken holds off the commit
// a clear request sweeps the 32 live-map rows, one per cycle, and shows its
//   result once the last row is cleared and the output is free
// reset: synchronous active low; then a clearing pass over the 32 live-map rows
//   with s_axis_tready low
module entity_id_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [eia_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [9:0] entity_id, rest zero
    input  logic [eia_pkg::S_USER_W-1:0]  s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [eia_pkg::M_DATA_W-1:0]  m_axis_tdata   // [1:0] status, [11:2] result_id,
                                                         // [12] is_live, [22:13] live_count
);

    eia_pkg::t_state                      r_state, n_state;
    eia_pkg::t_op                         r_op;
    logic [eia_pkg::ID_W-1:0]             r_id;
    logic [eia_pkg::ID_W-1:0]             r_tid, n_tid;
    logic                                 r_pop, n_pop;
    logic                                 r_full, n_full;
    logic                                 r_clr_pend;
    logic [eia_pkg::ROW_AW-1:0]           r_sweep;
    logic [eia_pkg::ID_W-1:0]             r_free_top;
    logic [eia_pkg::FRESH_W-1:0]          r_next_fresh;
    logic [eia_pkg::CNT_W-1:0]            r_live_total;
    logic                                 r_m_valid;
    eia_pkg::t_result                     r_res, n_res;

    // memories
    logic [eia_pkg::ROW_W-1:0]            r_live_mem [0:eia_pkg::ROWS-1];
    logic [eia_pkg::ROW_W-1:0]            r_row_q;
    logic [eia_pkg::ID_W-1:0]             r_stk_mem [0:eia_pkg::STK_DEPTH-1];
    logic [eia_pkg::ID_W-1:0]             r_stk_q;

    logic                                 in_acc;
    logic                                 out_free;
    logic                                 commit;
    logic                                 clr_done;
    logic                                 row_rd;
    logic [eia_pkg::ROW_AW-1:0]           row_rd_addr;
    logic                                 row_wr;
    logic [eia_pkg::ROW_AW-1:0]           row_wr_addr;
    logic [eia_pkg::ROW_W-1:0]            row_wr_data;
    logic                                 stk_rd;
    logic                                 stk_wr;
    logic                                 bit_live;
    logic                                 id_ok;
    logic                                 last_row;

    assign s_axis_tready = (r_state == eia_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(eia_pkg::M_DATA_W - $bits(eia_pkg::t_result)){1'b0}}, r_res};

    assign bit_live = r_row_q[r_tid[eia_pkg::BIT_AW-1:0]];
    assign id_ok    = (r_id != '0);
    assign last_row = (r_sweep == eia_pkg::ROW_AW'(eia_pkg::ROWS - 1));
    assign clr_done = (r_state == eia_pkg::S_SWEEP) && last_row && r_clr_pend && out_free;

    // stack read at acceptance, popping candidate below the top
    assign stk_rd = in_acc && (r_free_top != '0);

    // target id picked once the stack entry is available
    always_comb begin
        n_tid  = r_id;
        n_pop  = 1'b0;
        n_full = 1'b0;
        if (r_op == eia_pkg::OP_CREATE) begin
            if (r_free_top != '0) begin
                n_tid = r_stk_q;
                n_pop = 1'b1;
            end else if (r_next_fresh < eia_pkg::FRESH_W'(eia_pkg::MAX_IDS)) begin
                n_tid = r_next_fresh[eia_pkg::ID_W-1:0];
            end else begin
                n_full = 1'b1;
            end
        end
    end

    assign row_rd      = (r_state == eia_pkg::S_STACK);
    assign row_rd_addr = n_tid[eia_pkg::ID_W-1:eia_pkg::BIT_AW];
    assign commit      = (r_state == eia_pkg::S_ROW) && out_free;

    // result and live-row update at commit; row clearing and clear result during a sweep
    always_comb begin
        n_res            = '0;
        n_res.status     = eia_pkg::ST_OK;
        n_res.live_count = r_live_total;
        row_wr           = 1'b0;
        row_wr_addr      = r_tid[eia_pkg::ID_W-1:eia_pkg::BIT_AW];
        row_wr_data      = r_row_q;
        stk_wr           = 1'b0;
        if (r_state == eia_pkg::S_SWEEP) begin
            row_wr      = 1'b1;
            row_wr_addr = r_sweep;
            row_wr_data = '0;
            n_res.live_count = '0;
        end else begin
            case (r_op)
                eia_pkg::OP_CREATE: begin
                    if (r_full) begin
                        n_res.status = eia_pkg::ST_FULL;
                    end else begin
                        row_wr                                   = commit;
                        row_wr_data[r_tid[eia_pkg::BIT_AW-1:0]]  = 1'b1;
                        n_res.result_id                          = r_tid;
                        n_res.live_count                         = r_live_total + 1'b1;
                    end
                end
                eia_pkg::OP_DESTROY: begin
                    if (!id_ok || !bit_live) begin
                        n_res.status = eia_pkg::ST_BAD_ID;
                    end else begin
                        row_wr                                   = commit;
                        row_wr_data[r_tid[eia_pkg::BIT_AW-1:0]]  = 1'b0;
                        stk_wr = commit &&
                                 (r_free_top != eia_pkg::ID_W'(eia_pkg::STK_DEPTH));
                        if (r_live_total != '0) begin
                            n_res.live_count = r_live_total - 1'b1;
                        end
                    end
                end
                eia_pkg::OP_QUERY: begin
                    n_res.is_live = id_ok && bit_live;
                end
                default: begin
                    n_res.live_count = '0;
                end
            endcase
        end
    end

    // live map memory, one row per access
    always_ff @(posedge i_clk) begin
        if (row_wr) begin
            r_live_mem[row_wr_addr] <= row_wr_data;
        end
        if (row_rd) begin
            r_row_q <= r_live_mem[row_rd_addr];
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_wr) begin
            r_stk_mem[r_free_top] <= r_id;
        end
        if (stk_rd) begin
            r_stk_q <= r_stk_mem[r_free_top - 1'b1];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            eia_pkg::S_SWEEP: begin
                if (last_row && (!r_clr_pend || out_free)) begin
                    n_state = eia_pkg::S_IDLE;
                end
            end
            eia_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (eia_pkg::t_op'(s_axis_tuser) == eia_pkg::OP_CLEAR) ?
                              eia_pkg::S_SWEEP : eia_pkg::S_STACK;
                end
            end
            eia_pkg::S_STACK: n_state = eia_pkg::S_ROW;
            eia_pkg::S_ROW: begin
                if (commit) begin
                    n_state = eia_pkg::S_IDLE;
                end
            end
            default: n_state = eia_pkg::S_SWEEP;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= eia_pkg::S_SWEEP;
            r_sweep      <= '0;
            r_clr_pend   <= 1'b0;
            r_free_top   <= '0;
            r_next_fresh <= eia_pkg::FRESH_W'(1);
            r_live_total <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid, set at commit or at the end of a clear sweep
            if (commit || clr_done) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            // sweep counter, held on the last row until the result can go out
            if (r_state == eia_pkg::S_SWEEP && !last_row) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (clr_done) begin
                r_clr_pend <= 1'b0;
            end
            // clear request resets the counters at acceptance
            if (in_acc && eia_pkg::t_op'(s_axis_tuser) == eia_pkg::OP_CLEAR) begin
                r_sweep      <= '0;
                r_clr_pend   <= 1'b1;
                r_free_top   <= '0;
                r_next_fresh <= eia_pkg::FRESH_W'(1);
                r_live_total <= '0;
            end
            // commit of create, destroy or query
            if (commit) begin
                r_live_total <= n_res.live_count;
                if (r_op == eia_pkg::OP_CREATE && !r_full) begin
                    if (r_pop) begin
                        r_free_top <= r_free_top - 1'b1;
                    end else begin
                        r_next_fresh <= r_next_fresh + 1'b1;
                    end
                end
                if (stk_wr) begin
                    r_free_top <= r_free_top + 1'b1;
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= eia_pkg::t_op'(s_axis_tuser);
            r_id <= s_axis_tdata[eia_pkg::ID_W-1:0];
        end
        if (r_state == eia_pkg::S_STACK) begin
            r_tid  <= n_tid;
            r_pop  <= n_pop;
            r_full <= n_full;
        end
        if (commit || clr_done) begin
            r_res <= n_res;
        end
    end

endmodule
